[src/nf4_double_quant_decoder_defines.svh]
// Assertion macros for the NF4 decoder. Clocked on clk_i, disabled while rst_ni is low.
`ifndef NF4_DOUBLE_QUANT_DECODER_DEFINES_SVH
`define NF4_DOUBLE_QUANT_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define NF4DQ_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nf4dq assertion failed");
`define NF4DQ_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nf4dq assertion failed");
`else
`define NF4DQ_ASSERT_IMP(name, ante, cons)
`define NF4DQ_ASSERT_NXT(name, ante, cons)
`endif
`endif

[src/nf4dq_pkg.sv]
`timescale 1ns / 1ps
package nf4dq_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int PADDR_W = 3;
  localparam logic [0:0] REG_GLOBAL_SCALE = 1'b0;
  localparam logic [31:0] FP32_ONE = 32'h3F80_0000;
  localparam logic [31:0] FP32_INF = 32'h7F80_0000;

  localparam logic [31:0] NF4_LEVELS [16] = '{
    32'hBF80_0000, 32'hBF32_39B1, 32'hBF06_6B30, 32'hBECA_32A0,
    32'hBE91_A24D, 32'hBE3D_353F, 32'hBDBA_7871, 32'h0000_0000,
    32'h3DA2_FAFF, 32'h3E24_CAE3, 32'h3E7C_04DD, 32'h3EAD_033A,
    32'h3EE1_A4B8, 32'h3F10_07AB, 32'h3F39_13B3, 32'h3F80_0000
  };

  typedef struct packed {
    logic [7:0] packed_byte;
    logic [7:0] scale_code;
    logic       low_nibble_present;
  } nf4dq_item_t;

  typedef struct packed {
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic        second_valid;
  } nf4dq_result_t;

  // Work handed from the front to the back through the queue.
  typedef struct packed {
    logic [31:0] scale;
    logic [7:0]  codes;
    logic        present;
  } nf4dq_job_t;

  typedef struct packed {
    logic              zero;
    logic              special;
    logic signed [9:0] exp;
    logic [23:0]       man;
  } nf4dq_unp_t;

  // Exact E4M3 (bias 7, no specials) to fp32.
  function automatic logic [31:0] fp8_scale_decode(input logic [7:0] code);
    logic [31:0] r;
    r = {code[7], 31'b0};
    if (code[6:3] != 4'd0) begin
      r = {code[7], {4'b0, code[6:3]} + 8'd120, code[2:0], 20'b0};
    end else begin
      case (code[2:0])
        3'd0: r = {code[7], 31'b0};
        3'd1: r = {code[7], 8'd118, 23'b0};
        3'd2: r = {code[7], 8'd119, 23'b0};
        3'd3: r = {code[7], 8'd119, 1'b1, 22'b0};
        3'd4: r = {code[7], 8'd120, 23'b0};
        3'd5: r = {code[7], 8'd120, 2'b01, 21'b0};
        3'd6: r = {code[7], 8'd120, 2'b10, 21'b0};
        3'd7: r = {code[7], 8'd120, 2'b11, 21'b0};
        default: r = {code[7], 31'b0};
      endcase
    end
    return r;
  endfunction

  // Unpack and normalize one operand so the hidden bit sits at bit 23.
  function automatic nf4dq_unp_t fp_unpack(input logic [31:0] x);
    nf4dq_unp_t u;
    logic [23:0] m;
    logic [4:0]  lz;
    logic        found;
    m = {(x[30:23] != 8'd0), x[22:0]};
    lz = 5'd0;
    found = 1'b0;
    for (int i = 0; i < 24; i++) begin
      if (!found && m[23-i]) begin
        lz = 5'(i);
        found = 1'b1;
      end
    end
    u.zero = (x[30:0] == 31'd0);
    u.special = (x[30:23] == 8'hFF);
    u.man = m << lz;
    u.exp = ((x[30:23] == 8'd0) ? 10'sd1 : $signed({2'b0, x[30:23]})) - $signed({5'b0, lz});
    return u;
  endfunction

  // Normalize and round a 48-bit product, nearest even, with subnormals.
  function automatic logic [31:0] fp_round(input logic sign, input logic signed [10:0] e,
                                           input logic [47:0] p);
    logic [47:0]       pn;
    logic signed [10:0] e1;
    logic [10:0]       sh;
    logic [95:0]       wide;
    logic [30:0]       base;
    logic [30:0]       sum;
    logic              g;
    logic              st;
    logic              ovf;
    pn = p[47] ? p : (p << 1);
    e1 = p[47] ? e + 11'sd1 : e;
    ovf = (e1 >= 11'sd255);
    sh = 11'(11'sd1 - e1);
    wide = '0;
    if (e1 >= 11'sd1) begin
      base = {e1[7:0], pn[46:24]};
      g = pn[23];
      st = |pn[22:0];
    end else if (sh > 11'd48) begin
      base = '0;
      g = 1'b0;
      st = 1'b1;
    end else begin
      wide = {pn, 48'b0} >> sh;
      base = {7'b0, wide[95:72]};
      g = wide[71];
      st = |wide[70:0];
    end
    sum = base + {30'b0, g & (st | base[0])};
    if (ovf || sum[30:23] == 8'hFF) begin
      return {sign, FP32_INF[30:0]};
    end
    return {sign, sum};
  endfunction

endpackage

[src/nf4dq_fpmul.sv]
`timescale 1ns / 1ps
module nf4dq_fpmul import nf4dq_pkg::*; #(
  parameter int SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [31:0]      a_i,
  input  logic [31:0]      b_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [31:0]      prod_o,
  output logic [SideW-1:0] side_o
);

  nf4dq_unp_t ua, ub;
  logic v1_q, v2_q, v3_q;
  logic s1_q, z1_q, x1_q, s2_q, z2_q, x2_q;
  logic signed [9:0] ea1_q, eb1_q;
  logic [23:0] ma1_q, mb1_q;
  logic signed [10:0] e2_q;
  logic [47:0] p2_q;
  logic [31:0] prod_q;
  logic [SideW-1:0] side1_q, side2_q, side3_q;

  assign ua = fp_unpack(a_i);
  assign ub = fp_unpack(b_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // unpack
    s1_q    <= a_i[31] ^ b_i[31];
    x1_q    <= ua.special | ub.special;
    z1_q    <= ua.zero | ub.zero;
    ea1_q   <= ua.exp;
    eb1_q   <= ub.exp;
    ma1_q   <= ua.man;
    mb1_q   <= ub.man;
    side1_q <= side_i;
    // multiply
    s2_q    <= s1_q;
    x2_q    <= x1_q;
    z2_q    <= z1_q;
    p2_q    <= ma1_q * mb1_q;
    e2_q    <= 11'(ea1_q) + 11'(eb1_q) - 11'sd127;
    side2_q <= side1_q;
    // round
    if (x2_q) begin
      prod_q <= FP32_INF;
    end else if (z2_q) begin
      prod_q <= {s2_q, 31'b0};
    end else begin
      prod_q <= fp_round(s2_q, e2_q, p2_q);
    end
    side3_q <= side2_q;
  end

  assign valid_o = v3_q;
  assign prod_o  = prod_q;
  assign side_o  = side3_q;

endmodule

[src/nf4dq_front.sv]
`timescale 1ns / 1ps
module nf4dq_front import nf4dq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  nf4dq_item_t item_i,
  input  logic [31:0] global_scale_i,
  output logic        push_o,
  output nf4dq_job_t  job_o
);

  logic [31:0] prod;
  logic [8:0]  side;

  nf4dq_fpmul #(.SideW(9)) u_scale_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .a_i     (global_scale_i),
    .b_i     (fp8_scale_decode(item_i.scale_code)),
    .side_i  ({item_i.packed_byte, item_i.low_nibble_present}),
    .valid_o (push_o),
    .prod_o  (prod),
    .side_o  (side)
  );

  // Fall back to 1.0 on a zero or non-finite block scale.
  always_comb begin
    job_o.scale   = ((prod[30:23] == 8'hFF) || (prod[30:0] == 31'd0)) ? FP32_ONE : prod;
    job_o.codes   = side[8:1];
    job_o.present = side[0];
  end

endmodule

[src/nf4dq_queue.sv]
`timescale 1ns / 1ps
module nf4dq_queue import nf4dq_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  nf4dq_job_t data_i,
  input  logic       pop_i,
  output logic       valid_o,
  output nf4dq_job_t data_o,
  output logic       full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  nf4dq_job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      // wrap at the last entry so any depth works
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[src/nf4dq_back.sv]
`timescale 1ns / 1ps
module nf4dq_back import nf4dq_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  nf4dq_job_t    job_i,
  output logic          done_o,
  output nf4dq_result_t result_o
);

  logic [31:0] hi_prod, lo_prod;
  logic        hi_present, lo_present, lo_valid;

  nf4dq_fpmul #(.SideW(1)) u_hi_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .a_i     (job_i.scale),
    .b_i     (NF4_LEVELS[job_i.codes[7:4]]),
    .side_i  (job_i.present),
    .valid_o (done_o),
    .prod_o  (hi_prod),
    .side_o  (hi_present)
  );

  nf4dq_fpmul #(.SideW(1)) u_lo_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .a_i     (job_i.scale),
    .b_i     (NF4_LEVELS[job_i.codes[3:0]]),
    .side_i  (job_i.present),
    .valid_o (lo_valid),
    .prod_o  (lo_prod),
    .side_o  (lo_present)
  );

  always_comb begin
    result_o.first_value  = hi_prod;
    // drop the low element of an odd tail
    result_o.second_value = (lo_present && lo_valid) ? lo_prod : 32'd0;
    result_o.second_valid = hi_present;
  end

endmodule

[src/nf4_double_quant_decoder.sv]
`timescale 1ns / 1ps
// NF4 double-quantization decoder.
// Input channel: present a packed byte (two NF4 codes, high nibble first), its E4M3
//   block-scale code and the low-nibble-present flag on in_i and raise start; the
//   transaction is taken at each rising edge with start high and busy low.
// Output channel: done_o pulses for one cycle with the two fp32 values on result_o.
//   The receiver cannot hold results off; each one is valid only in that cycle.
// Path: from the accepting edge a transaction passes the block-scale multiplier,
//   the queue register and the element multipliers before done_o rises.
// Throughput: one transaction per cycle while busy is low. Each fp32 multiplier is
//   a 3-stage pipeline (unpack/normalize, 24x24 multiply, round): a byte per cycle.
// busy stays low in normal use: the queue between front and back drains every cycle.
// Configuration: APB register 0 (byte address 0) holds the fp32 global scale; it
//   resets to 1.0. Write it only while no transaction is in flight.
// Reset: asynchronous, active low; clears the pipeline valids and queue pointers,
//   so no stale result appears after reset.
`include "nf4_double_quant_decoder_defines.svh"
module nf4_double_quant_decoder import nf4dq_pkg::*; #(
  parameter int QDepth = QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  nf4dq_item_t        in_i,
  output logic               done_o,
  output nf4dq_result_t      result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [31:0] scale_q;
  logic        accept;
  logic        q_push, q_valid, q_full;
  nf4dq_job_t  q_in, q_out;

  // Config register: write in the APB access phase.
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_GLOBAL_SCALE) ? scale_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= FP32_ONE;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1] == REG_GLOBAL_SCALE) begin
      scale_q <= pwdata;
    end
  end

  // Hold off new transactions only if the queue is full.
  assign busy   = q_full;
  assign accept = start && !busy;

  nf4dq_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (accept),
    .item_i         (in_i),
    .global_scale_i (scale_q),
    .push_o         (q_push),
    .job_o          (q_in)
  );

  nf4dq_queue #(.Depth(QDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_valid),
    .valid_o (q_valid),
    .data_o  (q_out),
    .full_o  (q_full)
  );

  // Back end always takes the queue head: the output cannot stall.
  nf4dq_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .job_i    (q_out),
    .done_o   (done_o),
    .result_o (result_o)
  );

  `NF4DQ_ASSERT_IMP(a_no_overflow, q_push, !q_full)
  `NF4DQ_ASSERT_NXT(a_push_lands, q_push, q_valid)
  `NF4DQ_ASSERT_IMP(a_absent_zero, done_o && !result_o.second_valid, result_o.second_value == 32'd0)
  `NF4DQ_ASSERT_IMP(a_first_finite, done_o, result_o.first_value[30:23] != 8'hFF)

endmodule
